@@ sv/mfd_pkg.sv @@
// shared types and constants for the minifloat to double decoder
package mfd_pkg;

	localparam int unsigned RawW = 32;
	localparam int unsigned TwW = 6;
	localparam int unsigned EwW = 4;
	localparam int unsigned FwW = 5;
	localparam int unsigned DblW = 64;
	localparam int unsigned ClsW = 3;
	localparam int unsigned PosW = 5;
	localparam int unsigned QueueDepth = 2;

	localparam logic [10:0] DblBias = 11'd1023;
	localparam logic [63:0] DblQnan = 64'h7FF8000000000000;
	localparam logic [63:0] DblInf = 64'h7FF0000000000000;

	typedef enum logic [ClsW-1:0] {
		CLS_ZERO = 3'd0,
		CLS_SUB  = 3'd1,
		CLS_NORM = 3'd2,
		CLS_INF  = 3'd3,
		CLS_NAN  = 3'd4
	} cls_t;

	typedef struct packed {
		logic        sign;
		logic [9:0]  expo;
		logic [28:0] frac;
		logic [EwW-1:0] ew;
		logic [FwW-1:0] fw;
		cls_t        cls;
		logic        bad;
	} item_t;

endpackage

@@ sv/mfd_front.sv @@
// front stage: field extraction, format check and classification
module mfd_front import mfd_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [RawW-1:0] raw_bits,
	input  logic [TwW-1:0]  total_width,
	input  logic [EwW-1:0]  exponent_width,
	input  logic [FwW-1:0]  fraction_width,
	output logic           q_valid,
	input  logic           q_ready,
	output item_t          q_item
);

	logic        bad;
	logic [RawW-1:0] emask;
	logic [RawW-1:0] fmask;
	logic [RawW-1:0] e_full;
	logic [RawW-1:0] f_full;
	logic [RawW-1:0] sh;
	logic [6:0]  wsum;
	item_t       it;
	item_t       item_s1;
	logic        valid_s1;

	always_comb begin
		wsum = 7'(exponent_width) + 7'(fraction_width) + 7'd1;
		bad = (total_width < 6'd3) || (total_width > 6'd32) || (exponent_width < 4'd2)
			|| (exponent_width > 4'd10) || (fraction_width < 5'd1)
			|| (fraction_width > 5'd29) || (wsum > 7'(total_width));
		emask = ~({RawW{1'b1}} << exponent_width);
		fmask = ~({RawW{1'b1}} << fraction_width);
		sh = raw_bits >> fraction_width;
		e_full = sh & emask;
		f_full = raw_bits & fmask;
		sh = raw_bits >> (total_width - 6'd1);
		it.sign = sh[0];
		it.expo = e_full[9:0];
		it.frac = f_full[28:0];
		it.ew = exponent_width;
		it.fw = fraction_width;
		it.bad = bad;
		if (bad) begin
			it.cls = CLS_ZERO;
		end else if (e_full == '0) begin
			it.cls = (f_full == '0) ? CLS_ZERO : CLS_SUB;
		end else if (e_full == emask) begin
			it.cls = (f_full == '0) ? CLS_INF : CLS_NAN;
		end else begin
			it.cls = CLS_NORM;
		end
	end

	assign in_ready = !valid_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= it;
		end
	end

	assign q_valid = valid_s1;
	assign q_item = item_s1;

endmodule

@@ sv/mfd_queue.sv @@
// short queue between front and back
module mfd_queue import mfd_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  logic  rd_ready,
	output item_t rd_item
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	item_t mem_q [Depth];
	logic [PtrW-1:0] wp_q;
	logic [PtrW-1:0] rp_q;
	logic [PtrW:0]   cnt_q;
	logic wr_en;
	logic rd_en;

	assign wr_ready = cnt_q != (PtrW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;
	assign rd_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PtrW+1)'(Depth)) else $error("queue overflow");
	a_rd_when_data: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !rd_valid) else $error("read from empty queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");

endmodule

@@ sv/mfd_back.sv @@
// back stage: normalization and double assembly
module mfd_back import mfd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  item_t           q_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [DblW-1:0] double_bits,
	output logic [ClsW-1:0] value_class,
	output logic            format_error
);

	logic [PosW-1:0] p;
	logic [10:0] bias;
	logic [11:0] ex;
	logic [28:0] fr;
	logic [51:0] mant;
	logic [63:0] bits;
	logic [63:0] bits_s1;
	cls_t cls_s1;
	logic bad_s1;
	logic valid_s1;

	always_comb begin
		p = '0;
		for (int i = 0; i < 29; i++) begin
			if (q_item.frac[i]) begin
				p = PosW'(i);
			end
		end
		bias = ~(11'h7FF << (q_item.ew - 4'd1));
		fr = q_item.frac & ~(29'h1FFFFFFF << p);
		ex = '0;
		mant = '0;
		bits = '0;
		case (q_item.cls)
			CLS_SUB: begin
				ex = 12'(p) + 12'd1 - 12'(bias) - 12'(q_item.fw) + 12'(DblBias);
				mant = 52'({23'd0, fr} << (6'd52 - 6'(p)));
				bits = {q_item.sign, ex[10:0], mant};
			end
			CLS_NORM: begin
				ex = 12'(q_item.expo) - 12'(bias) + 12'(DblBias);
				mant = 52'({23'd0, q_item.frac} << (6'd52 - 6'(q_item.fw)));
				bits = {q_item.sign, ex[10:0], mant};
			end
			CLS_INF: bits = {q_item.sign, 63'd0} | DblInf;
			CLS_NAN: bits = DblQnan;
			default: bits = '0;
		endcase
	end

	assign q_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (q_ready) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_ready && q_valid) begin
			bits_s1 <= bits;
			cls_s1 <= q_item.cls;
			bad_s1 <= q_item.bad;
		end
	end

	assign out_valid = valid_s1;
	assign double_bits = bits_s1;
	assign value_class = cls_s1;
	assign format_error = bad_s1;

endmodule

@@ sv/minifloat_to_double_decoder_unit.sv @@
// top level of the minifloat to double decoder
// channel | signals                                                      | dir
// in      | in_valid in_ready raw_bits total_width exponent_width fraction_width | in
// out     | out_valid out_ready double_bits value_class format_error     | out
// one beat per cycle sustained while out_ready stays high
// front register, two-entry queue and output register decouple the sides
// reset clears valid state only; payload registers hold whatever they had
// a stall on the output fills the queue before the input stalls
module minifloat_to_double_decoder_unit import mfd_pkg::*; #(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [RawW-1:0] raw_bits,
	input  logic [TwW-1:0]  total_width,
	input  logic [EwW-1:0]  exponent_width,
	input  logic [FwW-1:0]  fraction_width,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [DblW-1:0] double_bits,
	output logic [ClsW-1:0] value_class,
	output logic            format_error
);

	logic  f_valid;
	logic  f_ready;
	item_t f_item;
	logic  b_valid;
	logic  b_ready;
	item_t b_item;

	mfd_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .raw_bits, .total_width,
		.exponent_width, .fraction_width,
		.q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
	);

	mfd_queue #(.Depth(Depth)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
	);

	mfd_back u_back (
		.clk, .arst_n,
		.q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
		.out_valid, .out_ready, .double_bits, .value_class, .format_error
	);

endmodule
